[sv/kfli_pkg.sv]
package kfli_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int FRAC_W = 16;

    typedef enum logic [1:0] {
        CMD_ADD_POS    = 2'd0,
        CMD_ADD_SCALE  = 2'd1,
        CMD_ADD_USCALE = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_QUERY = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [31:0]  key_time;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_out_x;
        logic signed [31:0] pos_out_y;
        logic signed [31:0] pos_out_z;
        logic signed [31:0] scale_out_x;
        logic signed [31:0] scale_out_y;
        logic signed [31:0] scale_out_z;
        logic [1:0]   status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LOAD_LO,
        S_LOAD_HI,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input word
        logic do_write;  // append key
        logic set_zero;  // result all zeros
        logic rd_time;   // read time at scan index
        logic scan_inc;
        logic scan_init;
        logic rd_lo;     // read key row lo
        logic rd_hi;     // read key row hi
        logic rd_last;   // read key row of the last key
        logic copy_hi;   // result is the row just read, directly
        logic div_start;
        logic div_step;
        logic mul_step;
        logic out_load;
        logic [1:0] status;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic empty;
        logic full;
        logic one_key;
        logic scan_stop;   // time read > query or end of scan
        logic below_first; // query at/before key 0
        logic above_last;  // query at/after last key
        logic div_done;
        logic mul_done;
        logic out_busy;
    } stat_t;

endpackage

[sv/keyframe_linear_interpolator.sv]
// steps: adds capture, write, then load the result; queries that clamp to an end key
// decide, read the row, copy it and load the result; others decide, scan (one stored
// time a cycle, up to MAX_KEYS), 2 row reads, divide, lerp six lanes and load the result
// throughput: one word at a time, next word taken the cycle after the result loads;
// the scan and one-bit-a-cycle divider set how long a query holds the block
// reset (aresetn low, synchronous): key count zero, default_scale 65536
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = kfli_pkg::MAX_KEYS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kfli_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kfli_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);
    import kfli_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic [31:0] dscale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) dscale_reg <= 32'd65536;
        else if (cfg_we) dscale_reg <= cfg_wdata;
    end

    kfli_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .stat(stat), .ctrl(ctrl)
    );

    kfli_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_word(s_data),
        .default_scale(dscale_reg), .ctrl(ctrl), .stat(stat),
        .out_word(m_data), .out_valid(m_valid), .out_ready(m_ready)
    );
endmodule

[sv/kfli_datapath.sv]
module kfli_datapath #(
    parameter int MAX_KEYS = kfli_pkg::MAX_KEYS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kfli_pkg::in_word_t   in_word,
    input  logic [31:0]          default_scale,
    input  kfli_pkg::ctrl_t      ctrl,
    output kfli_pkg::stat_t      stat,
    output kfli_pkg::out_word_t  out_word,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import kfli_pkg::*;

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    // memories: one time array, one key row array (pos xyz, scale xyz)
    logic [31:0]  time_mem [MAX_KEYS];
    logic [191:0] row_mem  [MAX_KEYS];

    in_word_t    in_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] time_addr;
    logic [IW-1:0] row_addr;
    logic [31:0] trd_reg;
    logic [31:0] tlo_reg;
    logic [31:0] last_time_reg;
    logic [191:0] rrd_reg;
    logic [191:0] lo_reg;
    logic [191:0] hi_reg;
    logic [191:0] res_reg;
    logic        lo_ld_reg;
    logic        hi_ld_reg;
    logic [16:0] cnt_reg;
    logic [47:0] rem_reg;
    logic [31:0] span_reg;
    logic [15:0] quo_reg;
    logic [2:0]  lane_reg;
    logic        scan_first_reg;
    out_word_t   out_reg;
    logic        out_valid_reg;

    logic [191:0] wr_row;
    logic [31:0] ds;
    logic [IW-1:0] last_idx;

    assign ds = default_scale;
    assign wr_idx = count_reg[IW-1:0];
    assign last_idx = IW'(count_reg - CW'(1));

    // while the scan advances, fetch the time that idx moves on to
    assign time_addr = ctrl.scan_inc ? IW'(idx_reg + IW'(1)) : idx_reg;

    always_comb begin
        if (ctrl.rd_last) row_addr = last_idx;
        else if (ctrl.rd_lo) row_addr = IW'(idx_reg - IW'(1));
        else row_addr = idx_reg;
    end

    always_comb begin
        unique case (in_reg.cmd)
            CMD_ADD_POS:
                wr_row = {in_reg.val_x, in_reg.val_y, in_reg.val_z, ds, ds, ds};
            CMD_ADD_USCALE:
                wr_row = {96'd0, in_reg.val_x, in_reg.val_x, in_reg.val_x};
            default:
                wr_row = {96'd0, in_reg.val_x, in_reg.val_y, in_reg.val_z};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.do_write) begin
            time_mem[wr_idx] <= in_reg.key_time;
            row_mem[wr_idx]  <= wr_row;
        end
        if (ctrl.rd_time) begin
            trd_reg <= time_mem[time_addr];
        end
        if (ctrl.rd_lo || ctrl.rd_hi || ctrl.rd_last) begin
            rrd_reg <= row_mem[row_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.do_write) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) in_reg <= in_word;
        if (ctrl.do_write) last_time_reg <= in_reg.key_time;
        if (ctrl.scan_init) begin
            idx_reg <= '0;
            scan_first_reg <= 1'b1;
        end else if (ctrl.scan_inc) begin
            idx_reg <= idx_reg + IW'(1);
            scan_first_reg <= 1'b0;
            tlo_reg <= trd_reg;
        end
    end

    // scan: read time[idx], stop when time > query or idx == last
    logic idx_last;
    assign idx_last = (idx_reg == last_idx);
    always_comb begin
        stat.is_query    = (in_reg.cmd == CMD_QUERY);
        stat.empty       = (count_reg == '0);
        stat.full        = (count_reg == CW'(MAX_KEYS));
        stat.one_key     = (count_reg == CW'(1));
        stat.below_first = scan_first_reg && (in_reg.key_time <= trd_reg);
        stat.above_last  = scan_first_reg && (in_reg.key_time >= last_time_reg);
        stat.scan_stop   = idx_last || (trd_reg > in_reg.key_time);
        stat.div_done    = cnt_reg[16];
        stat.mul_done    = (lane_reg == 3'd6);
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    // row loads and restoring divider, one quotient bit a cycle
    logic [48:0] rem_try;
    assign rem_try = {rem_reg, 1'b0} - {17'd0, span_reg};

    // one lane a cycle: res = a + floor((b-a)*t/65536)
    logic signed [31:0] la, lb;
    logic signed [32:0] ld;
    logic signed [49:0] lp;
    logic signed [33:0] lq;
    assign la = lo_reg[191 - 32*lane_reg -: 32];
    assign lb = hi_reg[191 - 32*lane_reg -: 32];
    assign ld = 33'(lb) - 33'(la);
    assign lp = 50'(ld) * $signed({34'd0, quo_reg});
    assign lq = 34'(lp >>> FRAC_W);

    // row data is registered in rrd_reg, then moved into lo/hi by a registered load flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_ld_reg <= 1'b0;
            hi_ld_reg <= 1'b0;
        end else begin
            lo_ld_reg <= ctrl.rd_lo;
            hi_ld_reg <= ctrl.rd_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (lo_ld_reg) lo_reg <= rrd_reg;
        if (hi_ld_reg) hi_reg <= rrd_reg;
        if (ctrl.copy_hi) res_reg <= rrd_reg;
        if (ctrl.div_start) begin
            rem_reg  <= {16'd0, in_reg.key_time - tlo_reg};
            span_reg <= trd_reg - tlo_reg;
            quo_reg  <= '0;
            cnt_reg  <= 17'd1;
            lane_reg <= '0;
        end else if (ctrl.div_step) begin
            if (!rem_try[48]) begin
                rem_reg <= rem_try[47:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[46:0], 1'b0};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            cnt_reg <= {cnt_reg[15:0], 1'b0};
        end else if (ctrl.mul_step) begin
            res_reg[191 - 32*lane_reg -: 32] <= 32'(34'(la) + lq);
            lane_reg <= lane_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_reg <= {(ctrl.set_zero ? 192'd0 : res_reg), ctrl.status};
        end
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;
endmodule

[sv/kfli_ctrl.sv]
module kfli_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  kfli_pkg::stat_t  stat,
    output kfli_pkg::ctrl_t  ctrl
);
    import kfli_pkg::*;

    state_t state_reg, state_next;
    logic   zero_reg, zero_next;
    logic [1:0] st_reg, st_next;
    logic   copy_reg, copy_next;
    logic   copy_first, copy_last, scan_more;

    // clamp to key 0 first, then to the last key, else scan for the bracket
    assign copy_first = stat.one_key || stat.below_first;
    assign copy_last  = !copy_first && stat.above_last;
    assign scan_more  = !(copy_first || stat.above_last || stat.scan_stop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            zero_reg  <= 1'b0;
            st_reg    <= ST_ADDED;
        end else begin
            state_reg <= state_next;
            zero_reg  <= zero_next;
            st_reg    <= st_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        zero_next  = zero_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SCAN_RD;
            S_SCAN_RD: begin
                // first cycle after capture: decide command
                if (!stat.is_query) begin
                    zero_next = 1'b1;
                    st_next = stat.full ? ST_FULL : ST_ADDED;
                    state_next = S_OUT;
                end else if (stat.empty) begin
                    zero_next = 1'b1;
                    st_next = ST_EMPTY;
                    state_next = S_OUT;
                end else begin
                    zero_next = 1'b0;
                    st_next = ST_QUERY;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (copy_first || stat.above_last) state_next = S_LOAD_HI;
                else if (stat.scan_stop) state_next = S_LOAD_LO;
                else state_next = S_SCAN_CHK;
            end
            S_LOAD_LO: state_next = S_LOAD_HI;
            S_LOAD_HI: state_next = copy_reg ? S_OUT : S_DIV;
            S_DIV: if (stat.div_done) state_next = S_MUL;
            S_MUL: if (stat.mul_done) state_next = S_OUT;
            S_OUT: if (!stat.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // copy path: load one row into result only, skip lerp
    always_ff @(posedge aclk) begin
        if (!aresetn) copy_reg <= 1'b0;
        else copy_reg <= copy_next;
    end
    always_comb begin
        copy_next = copy_reg;
        if (state_reg == S_SCAN_CHK) begin
            copy_next = copy_first || stat.above_last;
        end
    end

    // outputs; scan reads the next stored time each cycle in SCAN_CHK as idx advances
    always_comb begin
        ctrl = '0;
        ctrl.status = st_reg;
        ctrl.set_zero = zero_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                ctrl.capture = in_valid;
                ctrl.scan_init = in_valid;
            end
            S_SCAN_RD: begin
                ctrl.rd_time = 1'b1;
                ctrl.do_write = !stat.is_query && !stat.full;
            end
            S_SCAN_CHK: begin
                ctrl.scan_inc = scan_more;
                ctrl.rd_time = scan_more;
                // key 0 sits at idx, the last key has its own address
                ctrl.rd_hi = copy_first;
                ctrl.rd_last = copy_last;
                ctrl.rd_lo = !scan_more && !copy_first && !copy_last;
            end
            S_LOAD_LO: ctrl.rd_hi = 1'b1;
            S_LOAD_HI: begin
                ctrl.copy_hi = copy_reg;
                ctrl.div_start = !copy_reg;
            end
            S_DIV: ctrl.div_step = !copy_reg && !stat.div_done;
            S_MUL: ctrl.mul_step = !copy_reg && !stat.mul_done;
            S_OUT: ctrl.out_load = !stat.out_busy;
            default: ;
        endcase
    end
endmodule

[sv/kfli_checker.sv]
module kfli_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input kfli_pkg::out_word_t m_data
);
    import kfli_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");

    a_add_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_ADDED || m_data.status == ST_FULL)
        |-> m_data.pos_out_x == 0 && m_data.scale_out_x == 0)
        else $error("add result not zero");

    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");
endmodule

bind keyframe_linear_interpolator kfli_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import kfli_pkg::*;

    localparam int NKEYS = MAX_KEYS_DEF;

    // expected-result store and lerp predictor for the keyframe table
    class kf_scoreboard;
        logic [31:0] times[NKEYS];
        logic [31:0] row[NKEYS][6];
        int unsigned n_keys;
        logic [31:0] dflt_scale;
        out_word_t pending[$];
        int errors;

        function void clear();
            n_keys = 0;
            dflt_scale = 32'h0001_0000;
            pending.delete();
            errors = 0;
        endfunction

        function logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [16:0] t);
            longint sa, d, p, q;
            sa = longint'($signed(a));
            d = longint'($signed(b)) - sa;
            p = d * longint'(t);
            if (p >= 0) q = p >>> 16;
            else q = -((-p + 65535) >>> 16);
            return 32'(sa + q);
        endfunction

        function void note_input(in_word_t w);
            out_word_t r;
            int unsigned hi, lo;
            logic [63:0] num, quo;
            logic [16:0] t;
            r = '0;
            if (cmd_t'(w.cmd) != CMD_QUERY) begin
                if (n_keys >= NKEYS) begin
                    r.status = ST_FULL;
                end else begin
                    times[n_keys] = w.key_time;
                    if (cmd_t'(w.cmd) == CMD_ADD_POS) begin
                        row[n_keys] = '{w.val_x, w.val_y, w.val_z,
                                        dflt_scale, dflt_scale, dflt_scale};
                    end else if (cmd_t'(w.cmd) == CMD_ADD_USCALE) begin
                        row[n_keys] = '{0, 0, 0, w.val_x, w.val_x, w.val_x};
                    end else begin
                        row[n_keys] = '{0, 0, 0, w.val_x, w.val_y, w.val_z};
                    end
                    n_keys++;
                    r.status = ST_ADDED;
                end
            end else if (n_keys == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_QUERY;
                hi = 0;
                lo = 0;
                t = 0;
                if (n_keys == 1 || w.key_time <= times[0]) begin
                    lo = 0; hi = 0;
                end else if (w.key_time >= times[n_keys-1]) begin
                    lo = n_keys - 1; hi = lo;
                end else begin
                    hi = 1;
                    while (hi < n_keys - 1 && times[hi] <= w.key_time) hi++;
                    lo = hi - 1;
                    if (times[hi] > times[lo] && w.key_time >= times[lo]) begin
                        num = {32'd0, w.key_time - times[lo]} << 16;
                        quo = num / {32'd0, times[hi] - times[lo]};
                        t = (quo > 65535) ? 17'd65535 : quo[16:0];
                    end
                end
                r.pos_out_x = lerp(row[lo][0], row[hi][0], t);
                r.pos_out_y = lerp(row[lo][1], row[hi][1], t);
                r.pos_out_z = lerp(row[lo][2], row[hi][2], t);
                r.scale_out_x = lerp(row[lo][3], row[hi][3], t);
                r.scale_out_y = lerp(row[lo][4], row[hi][4], t);
                r.scale_out_z = lerp(row[lo][5], row[hi][5], t);
            end
            pending = {pending, r};
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pos_out_x !== e.pos_out_x)
                $display("%0t: pos_x exp %h got %h", $time, e.pos_out_x, got.pos_out_x);
            if (got.pos_out_y !== e.pos_out_y)
                $display("%0t: pos_y exp %h got %h", $time, e.pos_out_y, got.pos_out_y);
            if (got.pos_out_z !== e.pos_out_z)
                $display("%0t: pos_z exp %h got %h", $time, e.pos_out_z, got.pos_out_z);
            if (got.scale_out_x !== e.scale_out_x)
                $display("%0t: scale_x exp %h got %h", $time, e.scale_out_x, got.scale_out_x);
            if (got.scale_out_y !== e.scale_out_y)
                $display("%0t: scale_y exp %h got %h", $time, e.scale_out_y, got.scale_out_y);
            if (got.scale_out_z !== e.scale_out_z)
                $display("%0t: scale_z exp %h got %h", $time, e.scale_out_z, got.scale_out_z);
            if (got.status !== e.status)
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            if (got !== e) errors++;
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    kf_scoreboard sb;
    bit stim_done = 0;
    bit hold_off = 0;

    keyframe_linear_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function int unsigned gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    function logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 2**20)) - 2**19);
            default: return $urandom;
        endcase
    endfunction

    // valid stays up into the next word when there is no gap
    task automatic send_word(cmd_t c, logic [31:0] tm, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, bit gaps);
        int unsigned g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{cmd: c, key_time: tm, val_x: x, val_y: y, val_z: z};
        do @(posedge aclk); while (!s_ready);
        sb.note_input(s_data);
    endtask

    // quiet the block before touching the register
    task automatic write_scale(logic [31:0] v);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.dflt_scale = v;
    endtask

    // sorted table of random keys, mostly modest time steps
    task automatic build_table(int unsigned nk);
        logic [31:0] tm;
        tm = $urandom_range(0, 1000);
        for (int i = 0; i < nk; i++) begin
            send_word(cmd_t'($urandom_range(0, 2)), tm, rand_val(), rand_val(),
                      rand_val(), 1);
            if ($urandom_range(0, 7) == 0) tm = tm + 0;
            else tm = tm + $urandom_range(1, 3_000_000);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver: random stalls, and one long hold-off
    initial begin
        int unsigned g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        logic [31:0] lo_t;
        sb = new();
        sb.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty query, extremes, all add kinds, clamps, equal times
        send_word(CMD_QUERY, 32'h0, 0, 0, 0, 0);
        send_word(CMD_ADD_POS, 32'h0000_1000, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 0);
        send_word(CMD_QUERY, 32'hffff_ffff, 0, 0, 0, 0);
        send_word(CMD_ADD_SCALE, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'hffff_ffff, 0);
        send_word(CMD_ADD_USCALE, 32'h0001_0000, 32'h0002_0000, 32'h1234, 32'h5678, 0);
        send_word(CMD_ADD_POS, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 0);
        send_word(CMD_QUERY, 32'h0, 0, 0, 0, 0);
        send_word(CMD_QUERY, 32'h0000_1000, 0, 0, 0, 0);
        send_word(CMD_QUERY, 32'h0000_8000, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 0);
        send_word(CMD_QUERY, 32'h0001_0000, 0, 0, 0, 0);
        send_word(CMD_QUERY, 32'h8000_0000, 0, 0, 0, 0);
        send_word(CMD_QUERY, 32'hffff_fffe, 0, 0, 0, 0);
        send_word(CMD_QUERY, 32'hffff_ffff, 0, 0, 0, 0);

        write_scale(32'h7fff_ffff);
        for (int k = 0; k < 3; k++) begin
            // fill to the end, then one refused add and a query on a full table
            build_table(NKEYS - sb.n_keys);
            send_word(cmd_t'(k), 32'h5, 1, 2, 3, 0);
            send_word(CMD_QUERY, 32'h0000_2000, 0, 0, 0, 0);
            if (k == 0) begin
                write_scale(32'h8000_0000);
                aresetn <= 1'b1;
            end
            break;
        end

        // a fresh table needs reset-free emptying, so work on the full table
        // and afterwards rely on the store staying full: queries dominate
        hold_off = 1;
        for (int i = 0; i < 40; i++)
            send_word(CMD_QUERY, $urandom, 0, 0, 0, 0);
        for (int i = 0; i < 520; i++) begin
            lo_t = sb.times[$urandom_range(0, NKEYS-1)];
            if ($urandom_range(0, 9) == 0)
                send_word(cmd_t'($urandom_range(0, 2)), $urandom, rand_val(),
                          rand_val(), rand_val(), 1);
            else
                send_word(CMD_QUERY, ($urandom_range(0, 1)) ? lo_t + $urandom_range(0, 9)
                          : $urandom, rand_val(), rand_val(), rand_val(), 1);
            if (i == 260) write_scale(32'h0);
        end
        write_scale(32'h0001_0000);
        send_word(CMD_QUERY, 32'h0, 0, 0, 0, 0);
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
